// ===== rtl/core/tsfs_pkg.sv =====
// Shared types and constants for the text stream frame stripper.
`timescale 1ns / 1ps

package tsfs_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CAP_W    = 16;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned M_DATA_W = 88;
    localparam int unsigned M_USER_W = 2;

    typedef enum logic [1:0] {
        REG_TAG_BYTE       = 2'd0,
        REG_MAX_RECORD_LEN = 2'd1,
        REG_BURST_CAPACITY = 2'd2
    } t_reg_idx;

    localparam logic [BYTE_W-1:0] TAG_BYTE_RST       = 8'hFF;
    localparam logic [BYTE_W-1:0] MAX_RECORD_LEN_RST = 8'd128;
    localparam logic [CAP_W-1:0]  BURST_CAPACITY_RST = 16'hFFFF;

    typedef struct packed {
        logic [BYTE_W-1:0] tag_byte;
        logic [BYTE_W-1:0] max_record_len;
        logic [CAP_W-1:0]  burst_capacity;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              burst_last;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic [CAP_W-1:0]  burst_written;
        logic [CNT_W-1:0]  frames_total;
        logic [CNT_W-1:0]  bad_total;
        logic              in_record;
    } t_out_item;

endpackage

// ===== rtl/core/tsfs_cfg_regs.sv =====
// APB configuration registers for the frame stripper.
`timescale 1ns / 1ps

module tsfs_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsfs_pkg::PADDR_W-1:0] paddr,
    input  logic [tsfs_pkg::PDATA_W-1:0] pwdata,
    output logic [tsfs_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output tsfs_pkg::t_cfg              o_cfg
);
    import tsfs_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tag_byte       <= TAG_BYTE_RST;
            r_cfg.max_record_len <= MAX_RECORD_LEN_RST;
            r_cfg.burst_capacity <= BURST_CAPACITY_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_TAG_BYTE:       r_cfg.tag_byte       <= pwdata[BYTE_W-1:0];
                REG_MAX_RECORD_LEN: r_cfg.max_record_len <= pwdata[BYTE_W-1:0];
                REG_BURST_CAPACITY: r_cfg.burst_capacity <= pwdata[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TAG_BYTE:       prdata = PDATA_W'(r_cfg.tag_byte);
            REG_MAX_RECORD_LEN: prdata = PDATA_W'(r_cfg.max_record_len);
            REG_BURST_CAPACITY: prdata = PDATA_W'(r_cfg.burst_capacity);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/tsfs_in_stage.sv =====
// Input register stage holding one incoming byte transaction.
`timescale 1ns / 1ps

module tsfs_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [tsfs_pkg::BYTE_W-1:0] s_axis_tdata,
    input  logic                        s_axis_tlast,
    input  logic                        i_take,
    output logic                        o_vld,
    output tsfs_pkg::t_in_item          o_item
);
    import tsfs_pkg::*;

    logic     r_vld;
    logic     n_vld;
    t_in_item r_item;
    logic     w_acc;

    assign s_axis_tready = !r_vld || i_take;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_vld = r_vld;
        if (w_acc) begin
            n_vld = 1'b1;
        end else if (i_take) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item.in_byte    <= s_axis_tdata;
            r_item.burst_last <= s_axis_tlast;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// ===== rtl/core/tsfs_parser.sv =====
// Record parser: mode, counters and the registered result.
`timescale 1ns / 1ps

module tsfs_parser #(
    parameter int unsigned HEADER_BYTES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsfs_pkg::t_cfg     i_cfg,
    input  logic               i_vld,
    input  tsfs_pkg::t_in_item i_item,
    output logic               o_take,
    output logic               o_out_vld,
    input  logic               i_out_rdy,
    output tsfs_pkg::t_out_item o_out
);
    import tsfs_pkg::*;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_HDR  = 2'd1,
        MODE_PAY  = 2'd2
    } t_mode;

    t_mode             r_mode, n_mode;
    logic [BYTE_W-1:0] r_left, n_left;
    logic [CNT_W-1:0]  r_frames, n_frames;
    logic [CNT_W-1:0]  r_bad, n_bad;
    logic [CAP_W-1:0]  r_burst, n_burst;
    logic              r_out_vld;
    t_out_item         r_out, n_out;
    logic              w_adv;
    logic              w_fwd;
    logic [BYTE_W-1:0] w_dec;

    assign w_adv  = i_vld && (!r_out_vld || i_out_rdy);
    assign o_take = w_adv;
    assign w_dec  = r_left - BYTE_W'(1);

    always_comb begin
        n_mode   = r_mode;
        n_left   = r_left;
        n_frames = r_frames;
        n_bad    = r_bad;
        n_burst  = r_burst;
        w_fwd    = 1'b0;
        case (r_mode)
            MODE_TEXT: begin
                if (i_item.in_byte == i_cfg.tag_byte) begin
                    n_mode = MODE_HDR;
                    n_left = BYTE_W'(HEADER_BYTES);
                end else if (r_burst < i_cfg.burst_capacity) begin
                    w_fwd   = 1'b1;
                    n_burst = r_burst + CAP_W'(1);
                end
            end
            MODE_HDR: begin
                n_left = w_dec;
                if (w_dec == '0) begin
                    if (i_item.in_byte > i_cfg.max_record_len) begin
                        n_bad  = r_bad + CNT_W'(1);
                        n_mode = MODE_TEXT;
                    end else if (i_item.in_byte == '0) begin
                        n_frames = r_frames + CNT_W'(1);
                        n_mode   = MODE_TEXT;
                    end else begin
                        n_left = i_item.in_byte;
                        n_mode = MODE_PAY;
                    end
                end
            end
            MODE_PAY: begin
                n_left = w_dec;
                if (w_dec == '0) begin
                    n_frames = r_frames + CNT_W'(1);
                    n_mode   = MODE_TEXT;
                end
            end
            default: begin
                n_mode = MODE_TEXT;
            end
        endcase

        n_out.out_byte      = w_fwd ? i_item.in_byte : '0;
        n_out.out_valid     = w_fwd;
        n_out.burst_written = n_burst;
        n_out.frames_total  = n_frames;
        n_out.bad_total     = n_bad;
        n_out.in_record     = (n_mode != MODE_TEXT);

        // burst count restarts after the result is formed
        if (i_item.burst_last) begin
            n_burst = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_TEXT;
            r_left    <= '0;
            r_frames  <= '0;
            r_bad     <= '0;
            r_burst   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_adv) begin
                r_mode   <= n_mode;
                r_left   <= n_left;
                r_frames <= n_frames;
                r_bad    <= n_bad;
                r_burst  <= n_burst;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_vld = r_out_vld;
    assign o_out     = r_out;

endmodule

// ===== rtl/core/text_stream_frame_stripper_core.sv =====
// Top level of the text stream frame stripper.
`timescale 1ns / 1ps

// Strips tagged binary records from a byte stream and forwards the text bytes.
// One byte transaction is taken per clock cycle: the byte sits in an input
// register, the record state and counters update as the result lands in an
// output register, and throughput is one byte per cycle while the output
// side keeps up. Each input byte gives exactly one output transaction with
// the forwarded byte (zero if dropped), the burst count, the frame and
// bad-header totals, and whether the block is inside a record. The user must
// write configuration over APB only while idle; the block does not enforce it.

module text_stream_frame_stripper_core #(
    parameter int unsigned HEADER_BYTES = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsfs_pkg::PADDR_W-1:0]  paddr,
    input  logic [tsfs_pkg::PDATA_W-1:0]  pwdata,
    output logic [tsfs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] in_byte
    input  logic [tsfs_pkg::BYTE_W-1:0]   s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] out_byte, [23:8] burst_written, [55:24] frames_total, [87:56] bad_total
    output logic [tsfs_pkg::M_DATA_W-1:0] m_axis_tdata,
    // [0] out_valid, [1] in_record
    output logic [tsfs_pkg::M_USER_W-1:0] m_axis_tuser
);
    import tsfs_pkg::*;

    t_cfg      w_cfg;
    logic      w_in_vld;
    t_in_item  w_in_item;
    logic      w_take;
    t_out_item w_out;

    tsfs_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tsfs_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_take        (w_take),
        .o_vld         (w_in_vld),
        .o_item        (w_in_item)
    );

    tsfs_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_vld     (w_in_vld),
        .i_item    (w_in_item),
        .o_take    (w_take),
        .o_out_vld (m_axis_tvalid),
        .i_out_rdy (m_axis_tready),
        .o_out     (w_out)
    );

    assign m_axis_tdata = {w_out.bad_total, w_out.frames_total,
                           w_out.burst_written, w_out.out_byte};
    assign m_axis_tuser = {w_out.in_record, w_out.out_valid};

endmodule
